/* hw/rtl/vector_norm_sum_dot_defines.svh */
`ifndef VECTOR_NORM_SUM_DOT_DEFINES_SVH
`define VECTOR_NORM_SUM_DOT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define VNSD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector_norm_sum_dot: assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define VNSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector_norm_sum_dot: assertion failed");

`endif

/* hw/rtl/vnsd_pkg.sv */
`default_nettype none

package vnsd_pkg;

    localparam int ELEM_W      = 16;
    localparam int SUM_W       = 17;
    localparam int PROD_W      = 32;
    localparam int SQ_W        = 36;
    localparam int DOT_W       = 37;
    localparam int MAG_W       = 18;
    localparam int ROOT_W      = 38;
    localparam int MAX_DIM_DEF = 32;
    localparam int QUEUE_DEPTH = 4;

    // One word from the front end to the back end.
    typedef struct packed {
        logic signed [SUM_W-1:0] elem_sum;
        logic                    last;
        logic                    ovf;
        logic [SQ_W-1:0]         sq_a;
        logic [SQ_W-1:0]         sq_b;
        logic signed [DOT_W-1:0] dot;
    } word_t;

endpackage

`default_nettype wire

/* hw/rtl/vnsd_front.sv */
`default_nettype none

module vnsd_front #(
    parameter int MAX_DIM = vnsd_pkg::MAX_DIM_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic signed [vnsd_pkg::ELEM_W-1:0]   elem_a,
    input  logic signed [vnsd_pkg::ELEM_W-1:0]   elem_b,
    input  logic                                 last_elem,
    input  logic                                 q_ready,
    output logic                                 push,
    output vnsd_pkg::word_t                      push_word
);

    localparam int CNT_W = $clog2(MAX_DIM + 1);

    logic [CNT_W-1:0]                     cnt_reg;
    logic                                 ovf_reg;
    logic                                 s1_valid_reg;
    logic signed [vnsd_pkg::SUM_W-1:0]    s1_sum_reg;
    logic                                 s1_last_reg;
    logic                                 s1_take_reg;
    logic                                 s1_ovf_reg;
    logic [vnsd_pkg::PROD_W-2:0]          s1_sq_a_reg;
    logic [vnsd_pkg::PROD_W-2:0]          s1_sq_b_reg;
    logic signed [vnsd_pkg::PROD_W-1:0]   s1_dot_reg;
    logic [vnsd_pkg::SQ_W-1:0]            acc_a_reg;
    logic [vnsd_pkg::SQ_W-1:0]            acc_b_reg;
    logic signed [vnsd_pkg::DOT_W-1:0]    acc_dot_reg;

    logic                                 accept;
    logic                                 at_max;
    logic signed [vnsd_pkg::PROD_W-1:0]   prod_aa;
    logic signed [vnsd_pkg::PROD_W-1:0]   prod_bb;
    logic signed [vnsd_pkg::PROD_W-1:0]   prod_ab;
    logic [vnsd_pkg::SQ_W-1:0]            acc_a_next;
    logic [vnsd_pkg::SQ_W-1:0]            acc_b_next;
    logic signed [vnsd_pkg::DOT_W-1:0]    acc_dot_next;

    assign accept     = item_valid && !item_stall;
    assign push       = s1_valid_reg && q_ready;
    assign item_stall = s1_valid_reg && !q_ready;
    assign at_max     = (cnt_reg == CNT_W'(MAX_DIM));

    assign prod_aa = elem_a * elem_a;
    assign prod_bb = elem_b * elem_b;
    assign prod_ab = elem_a * elem_b;

    // A pair that came in past the maximum length still moves on, but adds nothing.
    always_comb
    begin
        acc_a_next   = acc_a_reg;
        acc_b_next   = acc_b_reg;
        acc_dot_next = acc_dot_reg;
        if (s1_take_reg)
        begin
            acc_a_next   = acc_a_reg + vnsd_pkg::SQ_W'(s1_sq_a_reg);
            acc_b_next   = acc_b_reg + vnsd_pkg::SQ_W'(s1_sq_b_reg);
            acc_dot_next = acc_dot_reg + vnsd_pkg::DOT_W'(s1_dot_reg);
        end
    end

    always_comb
    begin
        push_word.elem_sum = s1_sum_reg;
        push_word.last     = s1_last_reg;
        push_word.ovf      = s1_ovf_reg;
        push_word.sq_a     = acc_a_next;
        push_word.sq_b     = acc_b_next;
        push_word.dot      = acc_dot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            acc_a_reg    <= '0;
            acc_b_reg    <= '0;
            acc_dot_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                if (last_elem)
                begin
                    cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else if (at_max)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            else if (push)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (push)
            begin
                if (s1_last_reg)
                begin
                    acc_a_reg   <= '0;
                    acc_b_reg   <= '0;
                    acc_dot_reg <= '0;
                end
                else
                begin
                    acc_a_reg   <= acc_a_next;
                    acc_b_reg   <= acc_b_next;
                    acc_dot_reg <= acc_dot_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sum_reg  <= vnsd_pkg::SUM_W'(elem_a) + vnsd_pkg::SUM_W'(elem_b);
            s1_last_reg <= last_elem;
            s1_take_reg <= !at_max;
            s1_ovf_reg  <= ovf_reg || at_max;
            s1_sq_a_reg <= prod_aa[vnsd_pkg::PROD_W-2:0];
            s1_sq_b_reg <= prod_bb[vnsd_pkg::PROD_W-2:0];
            s1_dot_reg  <= prod_ab;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/vnsd_queue.sv */
`default_nettype none

module vnsd_queue #(
    parameter int DEPTH = vnsd_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vnsd_pkg::word_t push_word,
    output logic            q_ready,
    input  logic            pop,
    output logic            q_valid,
    output vnsd_pkg::word_t q_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vnsd_pkg::word_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign q_ready = (cnt_reg != CNT_W'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_word  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/vnsd_back.sv */
`default_nettype none

module vnsd_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    input  vnsd_pkg::word_t                      q_word,
    output logic                                 pop,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic signed [vnsd_pkg::SUM_W-1:0]    elem_sum,
    output logic                                 done_res,
    output logic [vnsd_pkg::MAG_W-1:0]           mag_a,
    output logic [vnsd_pkg::MAG_W-1:0]           mag_b,
    output logic signed [vnsd_pkg::DOT_W-1:0]    dot_prod,
    output logic                                 length_error
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [vnsd_pkg::ROOT_W-1:0] rem;
        logic [vnsd_pkg::ROOT_W-1:0] root;
    } root_step_t;

    // One step of the bit-pair square root: one result bit settles per step.
    function automatic root_step_t root_step(
        input logic [vnsd_pkg::ROOT_W-1:0] rem,
        input logic [vnsd_pkg::ROOT_W-1:0] root,
        input logic [vnsd_pkg::ROOT_W-1:0] bit_val
    );
        logic [vnsd_pkg::ROOT_W-1:0] trial;
        root_step_t                  res;
        trial = root + bit_val;
        if (rem >= trial)
        begin
            res.rem  = rem - trial;
            res.root = (root >> 1) + bit_val;
        end
        else
        begin
            res.rem  = rem;
            res.root = root >> 1;
        end
        return res;
    endfunction

    state_t                              state_reg;
    logic                                res_valid_reg;
    logic signed [vnsd_pkg::SUM_W-1:0]   elem_sum_reg;
    logic                                done_reg;
    logic [vnsd_pkg::MAG_W-1:0]          mag_a_reg;
    logic [vnsd_pkg::MAG_W-1:0]          mag_b_reg;
    logic signed [vnsd_pkg::DOT_W-1:0]   dot_reg;
    logic                                lerr_reg;
    logic [vnsd_pkg::ROOT_W-1:0]         rem_a_reg;
    logic [vnsd_pkg::ROOT_W-1:0]         root_a_reg;
    logic [vnsd_pkg::ROOT_W-1:0]         rem_b_reg;
    logic [vnsd_pkg::ROOT_W-1:0]         root_b_reg;
    logic [vnsd_pkg::ROOT_W-1:0]         bit_reg;
    logic signed [vnsd_pkg::SUM_W-1:0]   hold_sum_reg;
    logic                                hold_ovf_reg;
    logic signed [vnsd_pkg::DOT_W-1:0]   hold_dot_reg;

    logic       out_free;
    logic       res_load;
    root_step_t step_a;
    root_step_t step_b;

    assign out_free = !res_valid_reg || !res_stall;
    assign pop      = (state_reg == ST_IDLE) && q_valid && out_free;
    // The output register takes a new word from an open pair or from a finished root.
    assign res_load = (pop && !q_word.last) || ((state_reg == ST_DONE) && out_free);

    assign step_a = root_step(rem_a_reg, root_a_reg, bit_reg);
    assign step_b = root_step(rem_b_reg, root_b_reg, bit_reg);

    assign res_valid    = res_valid_reg;
    assign elem_sum     = elem_sum_reg;
    assign done_res     = done_reg;
    assign mag_a        = mag_a_reg;
    assign mag_b        = mag_b_reg;
    assign dot_prod     = dot_reg;
    assign length_error = lerr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            elem_sum_reg  <= '0;
            done_reg      <= 1'b0;
            mag_a_reg     <= '0;
            mag_b_reg     <= '0;
            dot_reg       <= '0;
            lerr_reg      <= 1'b0;
            rem_a_reg     <= '0;
            root_a_reg    <= '0;
            rem_b_reg     <= '0;
            root_b_reg    <= '0;
            bit_reg       <= '0;
            hold_sum_reg  <= '0;
            hold_ovf_reg  <= 1'b0;
            hold_dot_reg  <= '0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        if (q_word.last)
                        begin
                            rem_a_reg    <= vnsd_pkg::ROOT_W'(q_word.sq_a);
                            rem_b_reg    <= vnsd_pkg::ROOT_W'(q_word.sq_b);
                            root_a_reg   <= '0;
                            root_b_reg   <= '0;
                            bit_reg      <= vnsd_pkg::ROOT_W'(1) << (vnsd_pkg::ROOT_W - 2);
                            hold_sum_reg <= q_word.elem_sum;
                            hold_ovf_reg <= q_word.ovf;
                            hold_dot_reg <= q_word.dot;
                            state_reg    <= ST_ROOT;
                        end
                        else
                        begin
                            elem_sum_reg  <= q_word.elem_sum;
                            done_reg      <= 1'b0;
                            mag_a_reg     <= '0;
                            mag_b_reg     <= '0;
                            dot_reg       <= '0;
                            lerr_reg      <= q_word.ovf;
                        end
                    end
                end
                ST_ROOT:
                begin
                    rem_a_reg  <= step_a.rem;
                    root_a_reg <= step_a.root;
                    rem_b_reg  <= step_b.rem;
                    root_b_reg <= step_b.root;
                    bit_reg    <= bit_reg >> 2;
                    if (bit_reg == vnsd_pkg::ROOT_W'(1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        elem_sum_reg  <= hold_sum_reg;
                        done_reg      <= 1'b1;
                        mag_a_reg     <= root_a_reg[vnsd_pkg::MAG_W-1:0];
                        mag_b_reg     <= root_b_reg[vnsd_pkg::MAG_W-1:0];
                        dot_reg       <= hold_dot_reg;
                        lerr_reg      <= hold_ovf_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/vector_norm_sum_dot.sv */
// Path: a word that is not last passes the front-end register and the queue into the output register.
// A last word also runs both square roots (19 steps) in the back end before its result is loaded.
// Throughput: one word per cycle while no last word is in the back end and no stall holds the flow; a last
// word holds the back end through its roots, and the queue (4 entries by default) absorbs input meanwhile.
// Reset: rst_n is asynchronous, active low; it clears all accumulators, counts and queues.
`default_nettype none

module vector_norm_sum_dot #(
    parameter int MAX_DIM     = vnsd_pkg::MAX_DIM_DEF,
    parameter int QUEUE_DEPTH = vnsd_pkg::QUEUE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic signed [vnsd_pkg::ELEM_W-1:0]   elem_a,
    input  logic signed [vnsd_pkg::ELEM_W-1:0]   elem_b,
    input  logic                                 last_elem,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic signed [vnsd_pkg::SUM_W-1:0]    elem_sum,
    output logic                                 done_res,
    output logic [vnsd_pkg::MAG_W-1:0]           mag_a,
    output logic [vnsd_pkg::MAG_W-1:0]           mag_b,
    output logic signed [vnsd_pkg::DOT_W-1:0]    dot_prod,
    output logic                                 length_error
);

    logic            push;
    vnsd_pkg::word_t push_word;
    logic            q_ready;
    logic            pop;
    logic            q_valid;
    vnsd_pkg::word_t q_word;

    vnsd_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .elem_a     (elem_a),
        .elem_b     (elem_b),
        .last_elem  (last_elem),
        .q_ready    (q_ready),
        .push       (push),
        .push_word  (push_word)
    );

    vnsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_word    (q_word)
    );

    vnsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_word       (q_word),
        .pop          (pop),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .elem_sum     (elem_sum),
        .done_res     (done_res),
        .mag_a        (mag_a),
        .mag_b        (mag_b),
        .dot_prod     (dot_prod),
        .length_error (length_error)
    );

endmodule

`default_nettype wire

/* hw/rtl/vnsd_checker.sv */
`default_nettype none
`include "vector_norm_sum_dot_defines.svh"

module vnsd_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 res_valid,
    input wire logic                                 res_stall,
    input wire logic signed [vnsd_pkg::SUM_W-1:0]    elem_sum,
    input wire logic                                 done_res,
    input wire logic [vnsd_pkg::MAG_W-1:0]           mag_a,
    input wire logic [vnsd_pkg::MAG_W-1:0]           mag_b,
    input wire logic signed [vnsd_pkg::DOT_W-1:0]    dot_prod
);

    // A word that does not close a vector carries no magnitudes and no dot product.
    `VNSD_ASSERT_IMP(a_open_word_zero, res_valid && !done_res, mag_a == '0 && mag_b == '0 && dot_prod == '0)

    // Magnitudes never exceed the root of the largest possible sum of squares.
    `VNSD_ASSERT_IMP(a_mag_range, res_valid && done_res, mag_a <= 18'd185363 && mag_b <= 18'd185363)

    `VNSD_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(elem_sum) && $stable(mag_a) && $stable(dot_prod))

endmodule

bind vector_norm_sum_dot vnsd_checker u_vnsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .elem_sum  (elem_sum),
    .done_res  (done_res),
    .mag_a     (mag_a),
    .mag_b     (mag_b),
    .dot_prod  (dot_prod)
);

`default_nettype wire
